// File: sv/mtpl_pkg.sv
// ---------------------------------------------------------------------------
// Modbus thermometer poll link package
// Shared constants, codes, types and CRC helpers for the poll link blocks.
// ---------------------------------------------------------------------------
package mtpl_pkg;

  // Reply frame geometry.
  localparam int FRAME_LEN = 17;
  localparam int FILL_W    = $clog2(FRAME_LEN + 1);
  localparam int CRC_LEN   = FRAME_LEN - 2;
  localparam int REQ_BODY  = 6;
  localparam int REQ_LEN   = 8;
  localparam int SEQ_W     = $clog2(REQ_LEN);
  localparam int CNT_W     = 5;

  localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

  // Input actions.
  localparam logic [1:0] ACT_RX   = 2'd0;
  localparam logic [1:0] ACT_SEND = 2'd1;
  localparam logic [1:0] ACT_END  = 2'd2;
  localparam logic [1:0] ACT_TICK = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_RXERR = 2'd2;
  localparam logic [1:0] KIND_LINK  = 2'd3;

  // Protocol bytes.
  localparam logic [7:0] FUNC_READ  = 8'h03;
  localparam logic [7:0] BYTE_COUNT = 8'h0C;
  localparam logic [7:0] REG_COUNT  = 8'h06;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration register indexes.
  localparam logic REG_ADDR  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [7:0]  status_bits;
    logic [15:0] temp_a;
    logic [15:0] temp_b;
    logic [15:0] temp_c;
    logic [15:0] runtime_hours;
    logic [15:0] temp_d;
    logic        link_up;
  } res_t;

  // One byte of the reflected Modbus CRC16.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Body bytes of the read request, before the CRC.
  function automatic logic [7:0] req_byte(input logic [SEQ_W-1:0] pos,
                                          input logic [7:0]       addr);
    logic [7:0] b;
    case (pos)
      3'd0:    b = addr;
      3'd1:    b = FUNC_READ;
      3'd5:    b = REG_COUNT;
      default: b = ZERO_BYTE;
    endcase
    return b;
  endfunction

endpackage

// File: sv/mtpl_front.sv
// ---------------------------------------------------------------------------
// Poll link front end
// Takes requests from the input channel, classifies them and hands them to
// the command queue through a one-entry holding stage.
// ---------------------------------------------------------------------------
module mtpl_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_action,
  input  logic [7:0]       in_rx_byte,
  output logic             q_push,
  output mtpl_pkg::cmd_t   q_cmd,
  input  logic             q_full
);
  import mtpl_pkg::*;

  logic hold_valid_r, hold_valid_nxt;
  cmd_t hold_cmd_r, hold_cmd_nxt;
  logic accept;

  assign in_stall = hold_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = hold_valid_r && !q_full;
  assign q_cmd    = hold_cmd_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_cmd_nxt   = hold_cmd_r;
    if (q_push) begin
      hold_valid_nxt = 1'b0;
    end
    if (accept) begin
      hold_valid_nxt      = 1'b1;
      hold_cmd_nxt.action = in_action;
      // Only received bytes carry data; the byte is zeroed for control actions.
      hold_cmd_nxt.data   = (in_action == ACT_RX) ? in_rx_byte : ZERO_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_cmd_r <= hold_cmd_nxt;
  end

endmodule

// File: sv/mtpl_cmd_fifo.sv
// ---------------------------------------------------------------------------
// Poll link command queue
// Four-entry queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module mtpl_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mtpl_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output mtpl_pkg::cmd_t head_cmd,
  output logic           empty
);
  import mtpl_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == (PTR_W+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: sv/mtpl_back.sv
// ---------------------------------------------------------------------------
// Poll link back end
// Executes queued requests: reply window and frame hunt, request build,
// shared byte-wide CRC unit, link counters and the result register.
// ---------------------------------------------------------------------------
module mtpl_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_wdata,
  input  mtpl_pkg::cmd_t q_cmd,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output mtpl_pkg::res_t out_res
);
  import mtpl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CRC  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(FRAME_LEN);
  localparam logic [FILL_W-1:0] RX_LAST   = FILL_W'(CRC_LEN - 1);
  localparam logic [FILL_W-1:0] TX_LAST   = FILL_W'(REQ_BODY - 1);
  localparam logic [SEQ_W-1:0]  SEQ_LAST  = SEQ_W'(REQ_LEN - 1);
  localparam logic [SEQ_W-1:0]  SEQ_CRCLO = SEQ_W'(REQ_BODY);

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [1:0]        pend_kind_r, pend_kind_nxt;
  logic [7:0]        win_r [FRAME_LEN];
  logic [7:0]        win_nxt [FRAME_LEN];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              found_r, found_nxt;
  logic [CNT_W-1:0]  send_cnt_r, send_cnt_nxt;
  logic [CNT_W-1:0]  fail_cnt_r, fail_cnt_nxt;
  logic              link_r, link_nxt;
  logic [7:0]        addr_r;
  logic [3:0]        limit_r;
  logic [15:0]       crc_r, crc_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, res_d;

  logic [7:0]        crc_src;
  logic [15:0]       crc_step;
  logic              hdr_ok;
  logic              out_load;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  // The CRC unit walks either the request body or the reply window.
  assign crc_src  = (op_r == ACT_SEND) ? req_byte(idx_r[SEQ_W-1:0], addr_r)
                                       : win_r[idx_r];
  assign crc_step = crc_byte(crc_r, crc_src);
  assign hdr_ok   = (win_r[0] == addr_r) && (win_r[1] == FUNC_READ) &&
                    (win_r[2] == BYTE_COUNT);

  // Result being offered to the output register.
  always_comb begin
    res_d         = '0;
    res_d.kind    = pend_kind_r;
    res_d.link_up = link_r;
    case (pend_kind_r)
      KIND_TX: begin
        if (seq_r == SEQ_LAST) begin
          res_d.tx_byte = crc_r[15:8];
        end else if (seq_r == SEQ_CRCLO) begin
          res_d.tx_byte = crc_r[7:0];
        end else begin
          res_d.tx_byte = req_byte(seq_r, addr_r);
        end
        res_d.last = (seq_r == SEQ_LAST);
      end
      KIND_FRAME: begin
        res_d.status_bits   = win_r[4];
        res_d.temp_a        = {win_r[5], win_r[6]};
        res_d.temp_b        = {win_r[7], win_r[8]};
        res_d.temp_c        = {win_r[9], win_r[10]};
        res_d.runtime_hours = {win_r[11], win_r[12]};
        res_d.temp_d        = {win_r[13], win_r[14]};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pend_kind_nxt = pend_kind_r;
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    found_nxt     = found_r;
    send_cnt_nxt  = send_cnt_r;
    fail_cnt_nxt  = fail_cnt_r;
    link_nxt      = link_r;
    crc_nxt       = crc_r;
    idx_nxt       = idx_r;
    seq_nxt       = seq_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          op_nxt = q_cmd.action;
          case (q_cmd.action)
            ACT_RX: begin
              // Bytes after a decoded reply are dropped until end of buffer.
              if (!found_r) begin
                for (int i = 0; i < FRAME_LEN - 1; i++) begin
                  win_nxt[i] = win_r[i+1];
                end
                win_nxt[FRAME_LEN-1] = q_cmd.data;
                fill_nxt = (fill_r < FULL_FILL) ? fill_r + 1'b1 : fill_r;
                if (fill_nxt == FULL_FILL) begin
                  crc_nxt   = CRC_INIT;
                  idx_nxt   = '0;
                  state_nxt = S_CRC;
                end
              end
            end
            ACT_SEND: begin
              send_cnt_nxt = (send_cnt_r < COUNT_MAX) ? send_cnt_r + 1'b1 : COUNT_MAX;
              crc_nxt      = CRC_INIT;
              idx_nxt      = '0;
              state_nxt    = S_CRC;
            end
            ACT_END: begin
              if (!found_r) begin
                fail_cnt_nxt  = (fail_cnt_r < COUNT_MAX) ? fail_cnt_r + 1'b1 : COUNT_MAX;
                pend_kind_nxt = KIND_RXERR;
                state_nxt     = S_EMIT;
              end
              fill_nxt  = '0;
              found_nxt = 1'b0;
            end
            default: begin
              if (send_cnt_r > {1'b0, limit_r} || fail_cnt_r > {1'b0, limit_r}) begin
                send_cnt_nxt = '0;
                fail_cnt_nxt = '0;
                link_nxt     = 1'b0;
              end
              pend_kind_nxt = KIND_LINK;
              state_nxt     = S_EMIT;
            end
          endcase
        end
      end
      S_CRC: begin
        crc_nxt = crc_step;
        idx_nxt = idx_r + 1'b1;
        if (op_r == ACT_SEND) begin
          if (idx_r == TX_LAST) begin
            seq_nxt       = '0;
            pend_kind_nxt = KIND_TX;
            state_nxt     = S_EMIT;
          end
        end else if (idx_r == RX_LAST) begin
          if (hdr_ok && crc_step == {win_r[FRAME_LEN-1], win_r[FRAME_LEN-2]}) begin
            found_nxt     = 1'b1;
            link_nxt      = 1'b1;
            send_cnt_nxt  = '0;
            fail_cnt_nxt  = '0;
            pend_kind_nxt = KIND_FRAME;
            state_nxt     = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (pend_kind_r == KIND_TX && seq_r != SEQ_LAST) begin
            seq_nxt = seq_r + 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      found_r     <= 1'b0;
      send_cnt_r  <= '0;
      fail_cnt_r  <= '0;
      link_r      <= 1'b0;
      addr_r      <= 8'd1;
      limit_r     <= 4'd3;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      found_r     <= found_nxt;
      send_cnt_r  <= send_cnt_nxt;
      fail_cnt_r  <= fail_cnt_nxt;
      link_r      <= link_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ADDR:  addr_r  <= cfg_wdata;
          REG_LIMIT: limit_r <= cfg_wdata[3:0];
          default: begin
          end
        endcase
      end
    end
    op_r        <= op_nxt;
    pend_kind_r <= pend_kind_nxt;
    win_r       <= win_nxt;
    crc_r       <= crc_nxt;
    idx_r       <= idx_nxt;
    seq_r       <= seq_nxt;
    if (out_load) begin
      out_res_r <= res_d;
    end
  end

endmodule

// File: sv/modbus_thermometer_poll_link.sv
// ---------------------------------------------------------------------------
// Modbus thermometer poll link
// Modbus RTU master that polls one thermometer and decodes its replies.
// ---------------------------------------------------------------------------
// A request on the input channel is one of four actions. A send request
// produces eight results of kind 0, the read request "address, 03, 0000,
// 0006, CRC16" with the CRC low byte first and last set on the eighth byte;
// it walks the six body bytes through the CRC unit, one per cycle, and then
// gives one byte per cycle while the output side takes them. A received
// byte enters a 17-byte sliding window; once the window is full, each byte
// starts a walk of the single byte-wide CRC unit over the window, and a reply
// with the polled address, function 03, byte count 0C and a correct CRC
// yields one result of kind 1 with the status byte and the five data words,
// raises the link and clears the poll and failure counters. Later bytes of
// the same buffer are ignored. An end of buffer empties the window and, when
// no reply was found, raises the failure count and returns a kind 2 result.
// A timer tick returns the link state (kind 3) after dropping the link if
// either count is above fail_limit. A four-entry queue lets the input side
// keep taking requests while the back end works or the output register
// waits. The configuration port writes device_address (index 0) and
// fail_limit (index 1); the user must write them only while the block is
// idle, as the block itself does not enforce it.
// ---------------------------------------------------------------------------
module modbus_thermometer_poll_link (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_last,
  output logic [7:0]  out_status_bits,
  output logic [15:0] out_temp_a,
  output logic [15:0] out_temp_b,
  output logic [15:0] out_temp_c,
  output logic [15:0] out_runtime_hours,
  output logic [15:0] out_temp_d,
  output logic        out_link_up
);
  import mtpl_pkg::*;

  // Front end to queue.
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;

  // Queue to back end.
  cmd_t q_head_cmd;
  logic q_empty;
  logic q_pop;

  res_t res;

  mtpl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_rx_byte (in_rx_byte),
    .q_push     (q_push),
    .q_cmd      (q_push_cmd),
    .q_full     (q_full)
  );

  mtpl_cmd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (q_head_cmd),
    .empty    (q_empty)
  );

  mtpl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_cmd     (q_head_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  // The result register is split onto the individual field ports.
  assign out_kind          = res.kind;
  assign out_tx_byte       = res.tx_byte;
  assign out_last          = res.last;
  assign out_status_bits   = res.status_bits;
  assign out_temp_a        = res.temp_a;
  assign out_temp_b        = res.temp_b;
  assign out_temp_c        = res.temp_c;
  assign out_runtime_hours = res.runtime_hours;
  assign out_temp_d        = res.temp_d;
  assign out_link_up       = res.link_up;

endmodule

// File: sv/mtpl_checker.sv
// ---------------------------------------------------------------------------
// Poll link port checker
// Port-level assertions on the poll link, attached to the top level by bind.
// ---------------------------------------------------------------------------
module mtpl_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_tx_byte,
  input logic        out_last,
  input logic [7:0]  out_status_bits,
  input logic        out_link_up
);
  import mtpl_pkg::*;

  // Reset leaves no result on the output channel.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds its kind and byte.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_tx_byte))
    else $error("stalled result changed");

  // A decoded reply always reports the link as up.
  a_frame_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FRAME |-> out_link_up)
    else $error("decoded reply without link up");

  // Only request bytes carry the last flag or a transmit byte.
  a_last_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_TX |-> !out_last && out_tx_byte == ZERO_BYTE)
    else $error("request fields set on a non-request result");

  // Status bits appear only with a decoded reply.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_FRAME |-> out_status_bits == ZERO_BYTE)
    else $error("status bits on a non-reply result");

endmodule

bind modbus_thermometer_poll_link mtpl_port_checker u_mtpl_checker (.*);
